/* rtl/msprfp_pkg.sv */
// Package with the types, codes and sync constants of the MSP v1 response frame parser.
`default_nettype none

package msprfp_pkg;

  // Header sync bytes: '$' 'M' '>'
  localparam logic [7:0] SYNC_DOLLAR = 8'h24;
  localparam logic [7:0] SYNC_EM     = 8'h4D;
  localparam logic [7:0] SYNC_DIR    = 8'h3E;

  typedef enum logic [1:0] {
    CMD_ARM  = 2'd0,
    CMD_BYTE = 2'd1,
    CMD_TICK = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_DOLLAR  = 3'd1,
    PH_EM      = 3'd2,
    PH_DIR     = 3'd3,
    PH_SIZE    = 3'd4,
    PH_CMD     = 3'd5,
    PH_PAYLOAD = 3'd6,
    PH_CHECK   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BAD     = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_e;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef struct packed {
    phase_e      phase;
    logic [7:0]  wanted_command;
    logic [7:0]  frame_length;
    logic [7:0]  byte_count;
    logic [7:0]  running_xor;
    logic [15:0] ms_left;
  } state_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  rx_byte;
    logic [7:0]  expected_command;
    logic [15:0] timeout_ms;
  } item_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic [7:0] position;
    status_e    status;
    logic [7:0] length;
  } result_t;

  localparam state_t STATE_RESET = '{
    phase:          PH_IDLE,
    wanted_command: 8'd0,
    frame_length:   8'd0,
    byte_count:     8'd0,
    running_xor:    8'd0,
    ms_left:        16'd0
  };

endpackage : msprfp_pkg

`default_nettype wire

/* rtl/msprfp_step.sv */
// Next-state and result logic for one item of the MSP v1 response frame parser.
`default_nettype none

module msprfp_step (
  input  var msprfp_pkg::state_t  state_i,
  input  var msprfp_pkg::item_t   item_i,
  output msprfp_pkg::state_t      state_o,
  output logic                    res_valid_o,
  output msprfp_pkg::result_t     res_o
);

  logic [7:0]  count_inc;
  logic [15:0] ms_dec;

  assign count_inc = state_i.byte_count + 8'd1;
  assign ms_dec    = (state_i.ms_left != 16'd0) ? (state_i.ms_left - 16'd1) : 16'd0;

  always_comb begin
    state_o     = state_i;
    res_valid_o = 1'b0;
    res_o       = '{kind: msprfp_pkg::KIND_DATA, data: 8'd0, position: 8'd0,
                    status: msprfp_pkg::ST_OK, length: 8'd0};

    priority if (item_i.cmd == msprfp_pkg::CMD_ARM) begin
      // Arm: load target and timeout, clear frame state
      state_o.wanted_command = item_i.expected_command;
      state_o.ms_left        = item_i.timeout_ms;
      state_o.frame_length   = 8'd0;
      state_o.byte_count     = 8'd0;
      state_o.running_xor    = 8'd0;
      if (item_i.timeout_ms == 16'd0) begin
        state_o.phase = msprfp_pkg::PH_IDLE;
        res_valid_o   = 1'b1;
        res_o.kind    = msprfp_pkg::KIND_DONE;
        res_o.status  = msprfp_pkg::ST_TIMEOUT;
      end else begin
        state_o.phase = msprfp_pkg::PH_DOLLAR;
      end
    end else if (state_i.phase == msprfp_pkg::PH_IDLE) begin
      // Drop bytes and ticks while idle
    end else if (item_i.cmd == msprfp_pkg::CMD_BYTE) begin
      unique case (state_i.phase)
        msprfp_pkg::PH_DOLLAR: begin
          if (item_i.rx_byte == msprfp_pkg::SYNC_DOLLAR) state_o.phase = msprfp_pkg::PH_EM;
        end
        msprfp_pkg::PH_EM: begin
          state_o.phase = (item_i.rx_byte == msprfp_pkg::SYNC_EM) ?
                          msprfp_pkg::PH_DIR : msprfp_pkg::PH_DOLLAR;
        end
        msprfp_pkg::PH_DIR: begin
          state_o.phase = (item_i.rx_byte == msprfp_pkg::SYNC_DIR) ?
                          msprfp_pkg::PH_SIZE : msprfp_pkg::PH_DOLLAR;
        end
        msprfp_pkg::PH_SIZE: begin
          state_o.frame_length = item_i.rx_byte;
          state_o.running_xor  = item_i.rx_byte;
          state_o.phase        = msprfp_pkg::PH_CMD;
        end
        msprfp_pkg::PH_CMD: begin
          state_o.running_xor = state_i.running_xor ^ item_i.rx_byte;
          if (item_i.rx_byte != state_i.wanted_command) begin
            state_o.phase = msprfp_pkg::PH_DOLLAR;   // wrong command: resync
          end else if (state_i.frame_length == 8'd0) begin
            state_o.phase = msprfp_pkg::PH_CHECK;
          end else begin
            state_o.byte_count = 8'd0;
            state_o.phase      = msprfp_pkg::PH_PAYLOAD;
          end
        end
        msprfp_pkg::PH_PAYLOAD: begin
          res_valid_o          = 1'b1;
          res_o.data           = item_i.rx_byte;
          res_o.position       = state_i.byte_count;
          state_o.running_xor  = state_i.running_xor ^ item_i.rx_byte;
          state_o.byte_count   = count_inc;
          if (count_inc >= state_i.frame_length) state_o.phase = msprfp_pkg::PH_CHECK;
        end
        msprfp_pkg::PH_CHECK: begin
          res_valid_o   = 1'b1;
          res_o.kind    = msprfp_pkg::KIND_DONE;
          res_o.status  = (item_i.rx_byte == state_i.running_xor) ?
                          msprfp_pkg::ST_OK : msprfp_pkg::ST_BAD;
          res_o.length  = state_i.frame_length;
          state_o.phase = msprfp_pkg::PH_IDLE;
        end
        default: begin
        end
      endcase
    end else if (item_i.cmd == msprfp_pkg::CMD_TICK) begin
      state_o.ms_left = ms_dec;
      if (ms_dec == 16'd0) begin
        state_o.phase = msprfp_pkg::PH_IDLE;
        res_valid_o   = 1'b1;
        res_o.kind    = msprfp_pkg::KIND_DONE;
        res_o.status  = msprfp_pkg::ST_TIMEOUT;
      end
    end else begin
      // Unused command code: hold state
    end
  end

endmodule : msprfp_step

`default_nettype wire

/* rtl/msp_v1_response_frame_parser_unit.sv */
// Top level of the streaming MSP v1 response frame parser.
`default_nettype none

// Channel   Direction  Handshake              Fields
// input     in         in_valid_i/in_stall_o   cmd, rx_byte, expected_command, timeout_ms
// result    out        out_valid_o/out_stall_i kind, data, position, status, length
//
// One item per cycle sustained while the result side does not stall. An accepted
// item waits in the input register until it advances, is then processed by
// msprfp_step against the parser state, and its result (if any) is loaded into
// the result register, where it is taken downstream while out_stall_i is low.
// The input register only advances while the result register is free or being
// emptied, so a stall on the result side backs up into in_stall_o.
// Reset clears both valid flags and returns the parser to idle.

module msp_v1_response_frame_parser_unit (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  input  var logic        in_valid_i,
  output logic            in_stall_o,
  input  var logic [1:0]  cmd_i,
  input  var logic [7:0]  rx_byte_i,
  input  var logic [7:0]  expected_command_i,
  input  var logic [15:0] timeout_ms_i,
  output logic            out_valid_o,
  input  var logic        out_stall_i,
  output logic            kind_o,
  output logic [7:0]      data_o,
  output logic [7:0]      position_o,
  output logic [1:0]      status_o,
  output logic [7:0]      length_o
);

  logic                in_valid_q;
  msprfp_pkg::item_t   item_q;
  msprfp_pkg::state_t  state_q;
  msprfp_pkg::state_t  state_d;
  logic                res_valid;
  msprfp_pkg::result_t res;
  logic                out_valid_q;
  msprfp_pkg::result_t res_q;
  logic                advance;
  logic                in_take;

  // Process the held item once the result register can take its result
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  msprfp_step u_step (
    .state_i     (state_q),
    .item_i      (item_q),
    .state_o     (state_d),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Input register: valid flag under reset, payload without
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= '{cmd: cmd_i, rx_byte: rx_byte_i,
                  expected_command: expected_command_i, timeout_ms: timeout_ms_i};
    end
  end

  // Parser state: commit the next state when the item advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= msprfp_pkg::STATE_RESET;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register: load on advance, drop once taken downstream
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      res_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = res_q.kind;
  assign data_o      = res_q.data;
  assign position_o  = res_q.position;
  assign status_o    = res_q.status;
  assign length_o    = res_q.length;

  // A finished read always leaves the parser idle
  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid && res.kind == msprfp_pkg::KIND_DONE)
      |=> (state_q.phase == msprfp_pkg::PH_IDLE))
    else $error("parser not idle after a finished read");

  // A pending payload byte lies inside the frame still being parsed
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == msprfp_pkg::KIND_DATA)
      |-> (position_o < state_q.frame_length &&
           (state_q.phase == msprfp_pkg::PH_PAYLOAD ||
            state_q.phase == msprfp_pkg::PH_CHECK)))
    else $error("payload position outside frame");

  // A payload result carries no status or length
  a_data_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == msprfp_pkg::KIND_DATA)
      |-> (status_o == msprfp_pkg::ST_OK && length_o == 8'd0))
    else $error("payload result with status or length set");

  // No state change while the held item waits on a stalled result
  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |=> $stable(state_q))
    else $error("parser state moved during stall");

endmodule : msp_v1_response_frame_parser_unit

`default_nettype wire

/* test/msp_v1_response_frame_parser_unit_test.sv */
// Self-checking testbench for the streaming MSP v1 response frame parser.
module msp_v1_response_frame_parser_unit_test;
  import msprfp_pkg::*;

  localparam logic [1:0] CMD_SPARE = 2'd3;  // unused command code, parser must ignore it
  localparam int ITEM_TARGET = 1150;
  localparam int CALM_ITEMS  = 100;         // final stretch of stimulus runs without idling
  localparam int RUN_LIMIT   = 5_000_000;

  typedef struct {
    item_t it;
    bit    wait_drain;  // hold this item until every predicted result has arrived
  } queued_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  cmd_i = CMD_TICK;
  logic [7:0]  rx_byte_i = 8'd0;
  logic [7:0]  expected_command_i = 8'd0;
  logic [15:0] timeout_ms_i = 16'd0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        kind_o;
  logic [7:0]  data_o;
  logic [7:0]  position_o;
  logic [1:0]  status_o;
  logic [7:0]  length_o;

  msp_v1_response_frame_parser_unit dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .cmd_i              (cmd_i),
    .rx_byte_i          (rx_byte_i),
    .expected_command_i (expected_command_i),
    .timeout_ms_i       (timeout_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .data_o             (data_o),
    .position_o         (position_o),
    .status_o           (status_o),
    .length_o           (length_o)
  );

  always #5 clk_i = ~clk_i;

  queued_item_t pending_items[$];
  result_t      due_results[$];
  bit           drain_next = 1'b0;

  // Shadow copy of the parser state, advanced once per accepted item.
  phase_e      hunt_phase = PH_IDLE;
  logic [7:0]  want_cmd = 8'd0;
  logic [7:0]  frame_len = 8'd0;
  logic [7:0]  payload_idx = 8'd0;
  logic [7:0]  csum = 8'd0;
  logic [15:0] ms_remaining = 16'd0;

  int errors = 0;
  int items_taken = 0;
  int payload_seen = 0;
  int done_ok = 0;
  int done_bad = 0;
  int done_timeout = 0;

  // Advance the shadow parser by one item; flag and return the result it causes.
  task automatic parse_item(input item_t it, output bit got, output result_t res);
    logic [7:0] b;
    b = it.rx_byte;
    got = 1'b0;
    res = '0;
    if (it.cmd == CMD_ARM) begin
      want_cmd = it.expected_command;
      ms_remaining = it.timeout_ms;
      frame_len = 8'd0;
      payload_idx = 8'd0;
      csum = 8'd0;
      if (ms_remaining == 16'd0) begin
        // zero budget: give up at once and stay idle
        hunt_phase = PH_IDLE;
        got = 1'b1;
        res.kind = KIND_DONE;
        res.status = ST_TIMEOUT;
      end else begin
        hunt_phase = PH_DOLLAR;
      end
    end else if (hunt_phase != PH_IDLE) begin
      if (it.cmd == CMD_BYTE) begin
        case (hunt_phase)
          PH_DOLLAR: begin
            if (b == SYNC_DOLLAR) hunt_phase = PH_EM;
          end
          // a wrong sync byte sends the hunt back to '$' without rechecking it
          PH_EM: hunt_phase = (b == SYNC_EM) ? PH_DIR : PH_DOLLAR;
          PH_DIR: hunt_phase = (b == SYNC_DIR) ? PH_SIZE : PH_DOLLAR;
          PH_SIZE: begin
            frame_len = b;
            csum = b;
            hunt_phase = PH_CMD;
          end
          PH_CMD: begin
            csum = csum ^ b;
            if (b != want_cmd) begin
              hunt_phase = PH_DOLLAR;
            end else if (frame_len == 8'd0) begin
              hunt_phase = PH_CHECK;
            end else begin
              payload_idx = 8'd0;
              hunt_phase = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            got = 1'b1;
            res.kind = KIND_DATA;
            res.data = b;
            res.position = payload_idx;
            csum = csum ^ b;
            payload_idx = payload_idx + 8'd1;
            if (payload_idx >= frame_len) hunt_phase = PH_CHECK;
          end
          PH_CHECK: begin
            got = 1'b1;
            res.kind = KIND_DONE;
            res.status = (b == csum) ? ST_OK : ST_BAD;
            res.length = frame_len;
            hunt_phase = PH_IDLE;
          end
          default: ;
        endcase
      end else if (it.cmd == CMD_TICK) begin
        if (ms_remaining > 16'd0) ms_remaining = ms_remaining - 16'd1;
        if (ms_remaining == 16'd0) begin
          hunt_phase = PH_IDLE;
          got = 1'b1;
          res.kind = KIND_DONE;
          res.status = ST_TIMEOUT;
        end
      end
    end
  endtask

  function automatic bit field_ok(string name, int unsigned want, int unsigned seen);
    if (want != seen)
      $display("%0t: %s expected %0h actual %0h", $time, name, want, seen);
    return want == seen;
  endfunction

  // Stimulus builders. Unused fields carry random content.
  task automatic add_item(input logic [1:0] c, input logic [7:0] b, input logic [7:0] e,
                          input logic [15:0] t);
    queued_item_t q;
    q.it.cmd = c;
    q.it.rx_byte = b;
    q.it.expected_command = e;
    q.it.timeout_ms = t;
    q.wait_drain = drain_next;
    drain_next = 1'b0;
    pending_items.push_back(q);
  endtask

  task automatic push_arm(input logic [7:0] e, input logic [15:0] t);
    add_item(CMD_ARM, 8'($urandom), e, t);
  endtask

  task automatic push_byte(input logic [7:0] b);
    add_item(CMD_BYTE, b, 8'($urandom), 16'($urandom));
  endtask

  task automatic push_tick();
    add_item(CMD_TICK, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  task automatic push_spare();
    add_item(CMD_SPARE, 8'($urandom), 8'($urandom), 16'($urandom));
  endtask

  // Sprinkle ticks, spare codes and the odd re-arm between frame bytes.
  task automatic push_noise();
    if ($urandom_range(0, 13) == 0) push_tick();
    if ($urandom_range(0, 29) == 0) push_spare();
    if ($urandom_range(0, 119) == 0) push_arm(8'($urandom), 16'($urandom_range(1, 65535)));
  endtask

  function automatic logic [15:0] pick_timeout();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'hFFFF;
    if (r < 3) return 16'($urandom_range(1, 10));
    return 16'($urandom_range(64, 65535));
  endfunction

  // A mostly well-formed response: arm, optional junk, header, size, command,
  // payload and checksum, with occasional wrong command or corrupted checksum.
  task automatic push_frame();
    logic [7:0] c;
    logic [7:0] sz;
    logic [7:0] b;
    logic [7:0] x;
    int r;
    c = 8'($urandom);
    push_arm(c, pick_timeout());
    repeat ($urandom_range(0, 2)) push_byte(8'($urandom));
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_EM);
    push_byte(SYNC_DIR);
    r = $urandom_range(0, 59);
    if (r == 0) sz = 8'd255;
    else if (r < 6) sz = 8'd0;
    else sz = 8'($urandom_range(1, 16));
    push_byte(sz);
    x = sz;
    if ($urandom_range(0, 9) == 0) push_byte(c ^ 8'($urandom_range(1, 255)));
    else push_byte(c);
    x = x ^ c;
    for (int i = 0; i < sz; i++) begin
      push_noise();
      b = 8'($urandom);
      x = x ^ b;
      push_byte(b);
    end
    push_noise();
    if ($urandom_range(0, 4) == 0) push_byte(x ^ 8'($urandom_range(1, 255)));
    else push_byte(x);
  endtask

  // Monitor: take results, check them, and predict for every accepted item.
  bit in_took = 1'b0;

  always @(posedge clk_i) begin
    result_t want;
    result_t res;
    bit got;
    bit ok;
    in_took = rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $display("%0t: result with none expected: kind %0h data %0h position %0h status %0h length %0h",
                 $time, kind_o, data_o, position_o, status_o, length_o);
        errors++;
      end else begin
        want = due_results.pop_front();
        ok = field_ok("kind", want.kind, kind_o);
        ok = field_ok("data", want.data, data_o) && ok;
        ok = field_ok("position", want.position, position_o) && ok;
        ok = field_ok("status", want.status, status_o) && ok;
        ok = field_ok("length", want.length, length_o) && ok;
        if (!ok) errors++;
        if (want.kind == KIND_DATA) payload_seen++;
        else if (want.status == ST_OK) done_ok++;
        else if (want.status == ST_BAD) done_bad++;
        else done_timeout++;
      end
    end
    if (in_took) begin
      items_taken++;
      parse_item('{cmd: cmd_i, rx_byte: rx_byte_i, expected_command: expected_command_i,
                   timeout_ms: timeout_ms_i}, got, res);
      if (got) due_results.push_back(res);
    end
  end

  // Driver and receiver back-pressure, both updated on the falling edge.
  int send_gap = 0;
  int recv_gap = 0;
  int idle_level = 2;
  int cyc = 0;

  always @(negedge clk_i) begin
    queued_item_t q;
    bit calm;
    bit nv;
    bit st;
    if (rst_ni) begin
      cyc++;
      // change how busy the idling is every so often, level 0 means none
      if (cyc % 160 == 0) idle_level = $urandom_range(0, 3);
      calm = pending_items.size() < CALM_ITEMS;
      // advance only once the current item is gone; hold it while stalled
      if (!in_valid_i || in_took) begin
        nv = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].wait_drain && due_results.size() != 0)) begin
          q = pending_items.pop_front();
          cmd_i <= q.it.cmd;
          rx_byte_i <= q.it.rx_byte;
          expected_command_i <= q.it.expected_command;
          timeout_ms_i <= q.it.timeout_ms;
          nv = 1'b1;
          if (!calm && idle_level != 0 && $urandom_range(0, 7) < idle_level)
            send_gap = $urandom_range(1, 9);
        end
        in_valid_i <= nv;
      end
      if (recv_gap > 0) begin
        recv_gap--;
        st = 1'b1;
      end else if (!calm && idle_level != 0 && $urandom_range(0, 7) < idle_level) begin
        recv_gap = $urandom_range(0, 8);
        st = 1'b1;
      end else begin
        st = 1'b0;
      end
      out_stall_i <= st;
    end
  end

  initial begin
    #(RUN_LIMIT);
    $display("msp_v1_response_frame_parser_unit: mismatch");
    $finish;
  end

  initial begin
    int scenario;
    int r;
    // Directed: idle items are dropped, zero timeout, sync mismatches,
    // empty payload, command mismatch and a tick-driven timeout.
    push_tick();
    push_byte(SYNC_DOLLAR);
    push_spare();
    push_arm(8'h5A, 16'h0000);
    push_arm(8'hFF, 16'hFFFF);
    push_byte(SYNC_DOLLAR);
    push_byte(8'hA5);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_EM);
    push_byte(8'h00);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_EM);
    push_byte(SYNC_DIR);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(8'hFF);
    push_arm(8'h00, 16'd2);
    push_byte(SYNC_DOLLAR);
    push_byte(SYNC_EM);
    push_byte(SYNC_DIR);
    push_byte(8'h02);
    push_byte(8'h01);
    push_spare();
    push_tick();
    push_tick();

    // Random part: mostly well-formed frames, some broken ones and noise.
    scenario = 0;
    while (pending_items.size() < ITEM_TARGET) begin
      if (scenario % 25 == 0) drain_next = 1'b1;
      r = $urandom_range(0, 99);
      if (r < 70) begin
        push_frame();
      end else if (r < 85) begin
        push_arm(8'($urandom), pick_timeout());
        repeat ($urandom_range(1, 10)) begin
          case ($urandom_range(0, 5))
            0: push_tick();
            1: push_spare();
            2: push_byte(SYNC_DOLLAR);
            3: push_byte(SYNC_EM);
            default: push_byte(8'($urandom));
          endcase
        end
      end else if (r < 95) begin
        repeat ($urandom_range(1, 6)) begin
          case ($urandom_range(0, 2))
            0: push_tick();
            1: push_spare();
            default: push_byte(8'($urandom));
          endcase
        end
      end else begin
        push_arm(8'($urandom), 16'h0000);
      end
      scenario++;
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_items.size() == 0);
    wait (in_valid_i == 1'b0);
    wait (due_results.size() == 0);
    repeat (10) @(posedge clk_i);

    $display("%0d items accepted over %0d frame scenarios; %0d payload bytes checked",
             items_taken, scenario, payload_seen);
    $display("reads finished: %0d checksum ok, %0d checksum bad, %0d timed out",
             done_ok, done_bad, done_timeout);
    if (errors == 0) begin
      $display("msp_v1_response_frame_parser_unit: match");
    end else begin
      $display("msp_v1_response_frame_parser_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/msprfp_pkg.sv
rtl/msprfp_step.sv
rtl/msp_v1_response_frame_parser_unit.sv
test/msp_v1_response_frame_parser_unit_test.sv
